### design/dmpt_pkg.sv
// Package for the DNA trie matcher: default sizes, operation codes and the
// command and status bundles between the controller and the datapath.
// Depends on nothing.
package dmpt_pkg;

    localparam int MAX_PATTERN_LEN_DEF = 16;
    localparam int NODE_COUNT_DEF      = 1024;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_PATTERN = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;

    typedef struct packed {
        logic latch;        // capture symbol and last of the accepted transfer
        logic soft_clr;     // return counters, cursor and flags, but not the output valid, to reset values
        logic push;         // append the symbol to the text window
        logic rd_load;      // read the child slot of the load cursor
        logic rd_root;      // start a walk at the root with the oldest symbol
        logic rd_next;      // continue the walk one symbol deeper
        logic wr_init;      // zero one child slot of the root
        logic wr_zero;      // zero one child slot of a freshly allocated node
        logic ld_exist;     // the edge exists: follow it, mark on last
        logic ld_alloc;     // allocate a node for the missing edge
        logic ld_drop;      // store full: drop the rest of the pattern
        logic ld_finish;    // last symbol of a dropped pattern
        logic hit_set;
        logic hit_val;
        logic emit;         // send one result and retire the oldest start
    } t_dp_cmd;

    typedef struct packed {
        logic rd_null;
        logic rd_mark;
        logic walk_end;     // the symbol just walked is the newest in the window
        logic walk_max;     // the walk has reached the maximum pattern length
        logic node_full;
        logic k_last;
        logic fill_one;
        logic out_free;
        logic dropped;
        logic last;
    } t_dp_sts;

endpackage

### design/dmpt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module dmpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/dmpt_ctrl.sv
// Controller state machine of the DNA trie matcher: sequences root init,
// pattern loading, trie walks and result transfers. Depends on dmpt_pkg.
module dmpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_op,
    input  logic              i_last,
    output logic              o_ready,
    input  dmpt_pkg::t_dp_sts i_sts,
    output dmpt_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LDEC   = 3'd2;
    localparam logic [2:0] S_LZERO  = 3'd3;
    localparam logic [2:0] S_WSTART = 3'd4;
    localparam logic [2:0] S_WALK   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.wr_init = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_op)
                        dmpt_pkg::OP_CLEAR: begin
                            o_cmd.soft_clr = 1'b1;
                            n_state        = S_INIT;
                        end
                        dmpt_pkg::OP_PATTERN: begin
                            if (i_sts.dropped) begin
                                o_cmd.ld_finish = i_last;
                            end else begin
                                o_cmd.rd_load = 1'b1;
                                n_state       = S_LDEC;
                            end
                        end
                        dmpt_pkg::OP_TEXT: begin
                            o_cmd.push = 1'b1;
                            n_state    = S_WSTART;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LDEC: begin
                if (!i_sts.rd_null) begin
                    o_cmd.ld_exist = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_sts.node_full) begin
                    o_cmd.ld_drop = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.ld_alloc = 1'b1;
                    n_state        = S_LZERO;
                end
            end
            S_LZERO: begin
                o_cmd.wr_zero = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_IDLE;
                end
            end
            S_WSTART: begin
                o_cmd.rd_root = 1'b1;
                n_state       = S_WALK;
            end
            S_WALK: begin
                if (i_sts.rd_null) begin
                    o_cmd.hit_set = 1'b1;
                    n_state       = S_EMIT;
                end else if (i_sts.rd_mark) begin
                    o_cmd.hit_set = 1'b1;
                    o_cmd.hit_val = 1'b1;
                    n_state       = S_EMIT;
                end else if (i_sts.walk_end) begin
                    // A walk that runs out of symbols stays open unless the text
                    // has ended or the walk is already as long as any match.
                    if (i_sts.walk_max || i_sts.last) begin
                        o_cmd.hit_set = 1'b1;
                        n_state       = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.fill_one ? S_IDLE : S_WSTART;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/dmpt_dp.sv
// Datapath of the DNA trie matcher: trie node store, text window, counters
// and the result register. Depends on dmpt_pkg and dmpt_ram.
module dmpt_dp #(
    parameter int MAX_PATTERN_LEN = dmpt_pkg::MAX_PATTERN_LEN_DEF,
    parameter int NODE_COUNT      = dmpt_pkg::NODE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_symbol,
    input  logic              i_last,
    input  dmpt_pkg::t_dp_cmd i_cmd,
    output dmpt_pkg::t_dp_sts o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [15:0]       o_start_pos,
    output logic              o_hit,
    output logic              o_store_full,
    output logic              o_end_of_text
);

    localparam int NB = $clog2(NODE_COUNT);
    localparam int AW = NB + 2;
    localparam int EW = NB + 1;
    localparam int FB = $clog2(MAX_PATTERN_LEN + 1);
    localparam int DB = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    logic [NB-1:0] r_cursor;
    logic [NB-1:0] r_new;
    logic [NB:0]   r_node_cnt;
    logic [1:0]    r_sym;
    logic          r_last;
    logic [1:0]    r_k;
    logic          r_dropped;
    logic          r_sticky;
    logic [1:0]    r_window [MAX_PATTERN_LEN];
    logic [FB-1:0] r_fill;
    logic [DB-1:0] r_d;
    logic [15:0]   r_start;
    logic          r_hit;
    logic          r_out_valid;
    logic [15:0]   r_out_start;
    logic          r_out_hit;
    logic          r_out_full;
    logic          r_out_eot;

    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [EW-1:0] rdata;
    logic [NB-1:0] rd_id;
    logic [DB-1:0] d_next;
    logic [FB-1:0] d_plus;

    assign rd_id  = rdata[NB-1:0];
    assign d_next = r_d + 1'b1;
    assign d_plus = FB'(r_d) + 1'b1;

    always_comb begin
        if (i_cmd.rd_root) begin
            raddr = {NB'(0), r_window[0]};
        end else if (i_cmd.rd_next) begin
            raddr = {rd_id, r_window[d_next]};
        end else begin
            raddr = {r_cursor, i_symbol};
        end
        we    = 1'b0;
        waddr = {r_cursor, r_sym};
        wdata = '0;
        if (i_cmd.wr_init) begin
            we    = 1'b1;
            waddr = {NB'(0), r_k};
        end else if (i_cmd.wr_zero) begin
            we    = 1'b1;
            waddr = {r_new, r_k};
        end else if (i_cmd.ld_exist) begin
            we    = r_last;
            wdata = {1'b1, rd_id};
        end else if (i_cmd.ld_alloc) begin
            we    = 1'b1;
            wdata = {r_last, r_node_cnt[NB-1:0]};
        end
    end

    // Each entry holds the child node and whether a pattern ends at that child.
    dmpt_ram #(
        .WIDTH(EW),
        .DEPTH(NODE_COUNT * 4)
    ) u_child_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_window[r_fill[DB-1:0]] <= i_symbol;
        end else if (i_cmd.emit) begin
            for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) begin
                r_window[i] <= r_window[i+1];
            end
        end
        if (i_cmd.latch) begin
            r_sym  <= i_symbol;
            r_last <= i_last;
        end
        if (i_cmd.ld_alloc) begin
            r_new <= r_node_cnt[NB-1:0];
        end
        if (i_cmd.hit_set) begin
            r_hit <= i_cmd.hit_val;
        end
        if (i_cmd.rd_root) begin
            r_d <= '0;
        end else if (i_cmd.rd_next) begin
            r_d <= d_next;
        end
        if (i_cmd.emit) begin
            r_out_start <= r_start;
            r_out_hit   <= r_hit;
            r_out_full  <= r_sticky;
            r_out_eot   <= r_last && (r_fill == FB'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_node_cnt  <= (NB+1)'(1);
            r_k         <= '0;
            r_dropped   <= 1'b0;
            r_sticky    <= 1'b0;
            r_fill      <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.soft_clr) begin
                r_cursor   <= '0;
                r_node_cnt <= (NB+1)'(1);
                r_k        <= '0;
                r_dropped  <= 1'b0;
                r_sticky   <= 1'b0;
                r_fill     <= '0;
                r_start    <= '0;
            end
            if (i_cmd.wr_init || i_cmd.wr_zero) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.ld_exist) begin
                r_cursor <= r_last ? '0 : rd_id;
            end
            if (i_cmd.ld_alloc) begin
                r_cursor   <= r_last ? '0 : r_node_cnt[NB-1:0];
                r_node_cnt <= r_node_cnt + 1'b1;
                r_k        <= '0;
            end
            if (i_cmd.ld_drop) begin
                r_sticky  <= 1'b1;
                r_dropped <= !r_last;
                if (r_last) begin
                    r_cursor <= '0;
                end
            end
            if (i_cmd.ld_finish) begin
                r_dropped <= 1'b0;
                r_cursor  <= '0;
            end
            if (i_cmd.push) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.emit) begin
                r_fill <= r_fill - 1'b1;
                // The final result of a text returns the start count to zero.
                if (r_last && (r_fill == FB'(1))) begin
                    r_start <= '0;
                end else begin
                    r_start <= r_start + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.rd_null   = (rd_id == '0);
        o_sts.rd_mark   = rdata[NB];
        o_sts.walk_end  = (d_plus >= r_fill);
        o_sts.walk_max  = (d_plus >= FB'(MAX_PATTERN_LEN));
        o_sts.node_full = (r_node_cnt >= (NB+1)'(NODE_COUNT));
        o_sts.k_last    = (r_k == 2'd3);
        o_sts.fill_one  = (r_fill == FB'(1));
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.dropped   = r_dropped;
        o_sts.last      = r_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_start_pos   = r_out_start;
    assign o_hit         = r_out_hit;
    assign o_store_full  = r_out_full;
    assign o_end_of_text = r_out_eot;

endmodule

### design/dna_multi_pattern_trie_matcher.sv
// Multiple-pattern matcher for DNA text. Pattern symbols build a trie in a
// node store of NODE_COUNT nodes (four child slots each, in one RAM); text
// symbols fill a window of MAX_PATTERN_LEN symbols, and every start position
// is settled in order by a walk from the root, one RAM read per cycle. A
// pattern symbol is taken in and its child slot read, then the slot is
// decoded; when it allocates a node, the new node's four slots are zeroed
// next, while the rest of a dropped pattern is skipped as it is taken in. A
// text symbol is taken in, then, for each start position it settles, the
// walk is started, one symbol is walked at a time (at most MAX_PATTERN_LEN)
// and the result is handed over once the output is free; a walk that stays
// open is started and walked as well, and ends the item. After reset, and
// after a clear is taken, the root's slots are zeroed and no transfer is
// taken meanwhile. The output is a single register: one result can wait
// there while the block goes on, and the next result waits until it is
// taken, holding off the input meanwhile. Depends on dmpt_pkg, dmpt_ctrl and dmpt_dp.
module dna_multi_pattern_trie_matcher #(
    parameter int MAX_PATTERN_LEN = dmpt_pkg::MAX_PATTERN_LEN_DEF,
    parameter int NODE_COUNT      = dmpt_pkg::NODE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] start_pos, [16] hit, [17] store_full
    output logic        m_axis_tlast
);

    dmpt_pkg::t_dp_cmd cmd;
    dmpt_pkg::t_dp_sts sts;
    logic [15:0]       start_pos;
    logic              hit;
    logic              store_full;

    dmpt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .i_op   (s_axis_tuser),
        .i_last (s_axis_tlast),
        .o_ready(s_axis_tready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    dmpt_dp #(
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN),
        .NODE_COUNT     (NODE_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_symbol     (s_axis_tdata[1:0]),
        .i_last       (s_axis_tlast),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_start_pos  (start_pos),
        .o_hit        (hit),
        .o_store_full (store_full),
        .o_end_of_text(m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, store_full, hit, start_pos};

endmodule
